@@ hdl/wis_pkg.sv @@
// wis_pkg: constants, opcode and state types shared by the weighted index sampler.
// No dependencies; compile first.
`default_nettype none

package wis_pkg;

  localparam int MAX_WEIGHTS       = 256;
  localparam int WEIGHT_BITS       = 16;
  localparam int WEIGHT_FIELD_BITS = 16;
  localparam int FRAC_BITS         = 32;
  localparam int OUT_IDX_BITS      = 8;
  localparam int OP_BITS           = 2;

  localparam int IDX_BITS  = $clog2(MAX_WEIGHTS);
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int SUM_BITS  = WEIGHT_BITS + IDX_BITS;
  localparam int WUSE_BITS = (WEIGHT_BITS < WEIGHT_FIELD_BITS) ? WEIGHT_BITS : WEIGHT_FIELD_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_WAIT   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ hdl/wis_if.sv @@
// wis_cmd_if and wis_res_if: valid/ready channels for command and result words.
// Depends on wis_pkg.
`default_nettype none

interface wis_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [wis_pkg::OP_BITS-1:0]           op;
  logic [wis_pkg::WEIGHT_FIELD_BITS-1:0] weight;
  logic [wis_pkg::FRAC_BITS-1:0]         random_fraction;

  modport source (output valid, op, weight, random_fraction, input ready);
  modport sink   (input valid, op, weight, random_fraction, output ready);
endinterface

interface wis_res_if;
  logic                             valid;
  logic                             ready;
  logic [wis_pkg::OUT_IDX_BITS-1:0] index;
  logic                             error;

  modport source (output valid, index, error, input ready);
  modport sink   (input valid, index, error, output ready);
endinterface

`default_nettype wire

@@ hdl/wis_ram.sv @@
// wis_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/weighted_index_sampler.sv @@
// Weighted index sampler: a load word appends a weight and stores its prefix sum in RAM, a
// clear word empties the table, a sample word returns the first index whose prefix sum
// exceeds floor(random_fraction * total / 2^32), or error when the table or total is zero.
// Load, clear and unused op words are taken in the idle state. A sample word is taken in
// the idle state, the MUL state does the 32x24 scaling multiply, then the SEARCH state does
// one binary-search step per cycle, bound by the single registered read port of the
// prefix-sum RAM (a full table holds 256 entries). A result that finds the output register
// full, and every error sample, passes through the WAIT state. A finished result waits
// in the output register while later load and clear words are taken. No clearing pass after
// reset. Depends on wis_pkg, wis_if and wis_ram.
`default_nettype none

module weighted_index_sampler (
  input wire logic clk,
  input wire logic rst,
  wis_cmd_if.sink  cmd,
  wis_res_if.source result
);

  localparam int IB = wis_pkg::IDX_BITS;
  localparam int CB = wis_pkg::CNT_BITS;
  localparam int SB = wis_pkg::SUM_BITS;
  localparam int FB = wis_pkg::FRAC_BITS;

  wis_pkg::state_t state;

  logic [CB-1:0] count;
  logic [SB-1:0] total;
  logic [FB-1:0] frac;
  logic [SB-1:0] target;
  logic [CB-1:0] lo;
  logic [CB-1:0] hi;
  logic [IB-1:0] mid;
  logic          err;

  logic          out_valid;
  logic [wis_pkg::OUT_IDX_BITS-1:0] out_index;
  logic          out_error;

  logic          accept;
  logic          out_free;
  logic          load_out;
  logic          full;
  logic [SB-1:0] total_next;
  logic          ram_we;
  logic [IB-1:0] raddr;
  logic [SB-1:0] rdata;
  logic [FB+SB-1:0] product;
  logic          le;
  logic [CB-1:0] lo_next;
  logic [CB-1:0] hi_next;
  logic [CB:0]   mid_sum;
  logic [CB-1:0] fin_lo;
  logic [CB-1:0] clamped;

  assign cmd.ready     = (state == wis_pkg::ST_IDLE) && !rst;
  assign accept        = cmd.valid && cmd.ready;
  assign result.valid  = out_valid;
  assign result.index  = out_index;
  assign result.error  = out_error;
  assign out_free      = !out_valid || result.ready;

  assign full       = (count == CB'(wis_pkg::MAX_WEIGHTS));
  assign total_next = total + SB'(cmd.weight[wis_pkg::WUSE_BITS-1:0]);
  assign ram_we     = accept && (cmd.op == wis_pkg::OP_LOAD) && !full;

  assign product = {{SB{1'b0}}, frac} * {{FB{1'b0}}, total};

  // search step on the word read at mid
  assign le      = (rdata <= target);
  assign lo_next = le ? (CB'(mid) + CB'(1)) : lo;
  assign hi_next = le ? hi : CB'(mid);
  assign mid_sum = {1'b0, lo_next} + {1'b0, hi_next};

  assign load_out = out_free && ((state == wis_pkg::ST_WAIT) ||
                                 ((state == wis_pkg::ST_SEARCH) && (lo_next >= hi_next)));

  always_comb begin
    case (state)
      wis_pkg::ST_MUL:    raddr = count[CB-1:1];
      wis_pkg::ST_SEARCH: raddr = mid_sum[IB:1];
      default:            raddr = mid;
    endcase
  end

  assign fin_lo  = (state == wis_pkg::ST_SEARCH) ? lo_next : lo;
  assign clamped = (fin_lo >= count) ? (count - CB'(1)) : fin_lo;

  wis_ram #(
    .WIDTH (SB),
    .DEPTH (wis_pkg::MAX_WEIGHTS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IB-1:0]),
    .wdata (total_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wis_pkg::ST_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        wis_pkg::ST_IDLE: begin
          if (accept) begin
            case (cmd.op)
              wis_pkg::OP_LOAD: begin
                if (!full) begin
                  total <= total_next;
                  count <= count + CB'(1);
                end
              end
              wis_pkg::OP_SAMPLE: begin
                frac <= cmd.random_fraction;
                lo   <= '0;
                hi   <= count;
                if (count == '0 || total == '0) begin
                  err   <= 1'b1;
                  state <= wis_pkg::ST_WAIT;
                end else begin
                  err   <= 1'b0;
                  state <= wis_pkg::ST_MUL;
                end
              end
              wis_pkg::OP_CLEAR: begin
                count <= '0;
                total <= '0;
              end
              default: ;
            endcase
          end
        end
        wis_pkg::ST_MUL: begin
          target <= product[FB +: SB];
          mid    <= raddr;
          state  <= wis_pkg::ST_SEARCH;
        end
        wis_pkg::ST_SEARCH: begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= raddr;
          if (lo_next >= hi_next) begin
            if (out_free) begin
              out_index <= wis_pkg::OUT_IDX_BITS'(clamped);
              out_error <= 1'b0;
              state     <= wis_pkg::ST_IDLE;
            end else begin
              state <= wis_pkg::ST_WAIT;
            end
          end
        end
        wis_pkg::ST_WAIT: begin
          if (out_free) begin
            out_index <= err ? '0 : wis_pkg::OUT_IDX_BITS'(clamped);
            out_error <= err;
            state     <= wis_pkg::ST_IDLE;
          end
        end
        default: state <= wis_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == wis_pkg::ST_SEARCH) |-> (lo < hi && hi <= count))
    else $error("search window out of range");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CB'(wis_pkg::MAX_WEIGHTS))
    else $error("entry count above table size");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (total == '0))
    else $error("empty table with nonzero total");

  a_mul_to_search: assert property (@(posedge clk) disable iff (rst)
    (state == wis_pkg::ST_MUL) |=> (state == wis_pkg::ST_SEARCH))
    else $error("scaling step not followed by search");
`endif

endmodule

`default_nettype wire
